[sv/fpfs_pkg.sv]
// ----------------------------------------------------------------------------
// Flywheel plunger fire sequencer package
// Shared widths, codes and item types for the sequencer block.
// ----------------------------------------------------------------------------
package fpfs_pkg;

    localparam int ELAPSED_BITS = 16;
    localparam int DUTY_BITS    = 8;
    localparam int CMP_BITS     = (ELAPSED_BITS > 16) ? ELAPSED_BITS : 16;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DAT_BITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RUN_DUTY      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIGGER_HOLD  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROUND_GAP     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVUP_SEMI    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVUP_FULL    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVDOWN       = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_END_SETTLE    = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_RUN_DUTY     = 8'd120;
    localparam logic [15:0] RST_TRIGGER_HOLD = 16'd10;
    localparam logic [15:0] RST_ROUND_GAP    = 16'd10;
    localparam logic [15:0] RST_REVUP_SEMI   = 16'd500;
    localparam logic [15:0] RST_REVUP_FULL   = 16'd300;
    localparam logic [15:0] RST_REVDOWN      = 16'd2000;
    localparam logic [15:0] RST_END_SETTLE   = 16'd25;

    // Plunger drive modes.
    localparam logic [1:0] MODE_FWD   = 2'd0;
    localparam logic [1:0] MODE_BRAKE = 2'd2;

    // Flywheel ESC servo positions in degrees.
    localparam logic [7:0] ESC_PRE_RUN = 8'd96;
    localparam logic [7:0] ESC_REVUP   = 8'd160;
    localparam logic [7:0] ESC_RUN     = 8'd140;
    localparam logic [7:0] ESC_BRAKE   = 8'd15;

    localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_REVUP   = 3'd1,
        PH_CLEAR   = 3'd2,
        PH_RUN     = 3'd3,
        PH_DELAY   = 3'd4,
        PH_RELEASE = 3'd5
    } t_phase;

    typedef struct packed {
        logic fire_pulled;
        logic rev_pulled;
        logic plunger_home;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           motor_mode;
        logic [DUTY_BITS-1:0] motor_duty;
        logic [7:0]           esc_position;
        logic                 display_permit;
        logic [2:0]           fire_phase;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  run_duty;
        logic [15:0] trigger_hold_ms;
        logic [15:0] round_gap_ms;
        logic [15:0] revup_semi_ms;
        logic [15:0] revup_full_ms;
        logic [15:0] revdown_ms;
        logic [15:0] end_settle_ms;
    } t_cfg;

endpackage

[sv/fpfs_cfg.sv]
// ----------------------------------------------------------------------------
// Fire sequencer configuration registers
// Holds the seven timing and duty registers behind a valid/ready write port.
// ----------------------------------------------------------------------------
module fpfs_cfg
    import fpfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Every write is registered as it is offered, so the port never pushes back.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RUN_DUTY:     n_cfg.run_duty        = i_cfg_data[7:0];
                CFG_TRIGGER_HOLD: n_cfg.trigger_hold_ms = i_cfg_data;
                CFG_ROUND_GAP:    n_cfg.round_gap_ms    = i_cfg_data;
                CFG_REVUP_SEMI:   n_cfg.revup_semi_ms   = i_cfg_data;
                CFG_REVUP_FULL:   n_cfg.revup_full_ms   = i_cfg_data;
                CFG_REVDOWN:      n_cfg.revdown_ms      = i_cfg_data;
                CFG_END_SETTLE:   n_cfg.end_settle_ms   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.run_duty        <= RST_RUN_DUTY;
            r_cfg.trigger_hold_ms <= RST_TRIGGER_HOLD;
            r_cfg.round_gap_ms    <= RST_ROUND_GAP;
            r_cfg.revup_semi_ms   <= RST_REVUP_SEMI;
            r_cfg.revup_full_ms   <= RST_REVUP_FULL;
            r_cfg.revdown_ms      <= RST_REVDOWN;
            r_cfg.end_settle_ms   <= RST_END_SETTLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/fpfs_core.sv]
// ----------------------------------------------------------------------------
// Fire sequencer phase machine
// Phase register and saturating millisecond counter, stepped once per item.
// ----------------------------------------------------------------------------
module fpfs_core
    import fpfs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic [ELAPSED_BITS-1:0] w_tick;
    logic                    w_change;
    logic [15:0]             w_revup_ms;

    // True when the elapsed count is strictly past the threshold.
    function automatic logic past(input logic [ELAPSED_BITS-1:0] t,
                                  input logic [15:0] thr);
        logic [CMP_BITS-1:0] t_ext;
        logic [CMP_BITS-1:0] thr_ext;
        t_ext   = CMP_BITS'(t);
        thr_ext = CMP_BITS'(thr);
        return t_ext > thr_ext;
    endfunction

    // The tick counts first, so the decisions below see the incremented time.
    assign w_tick     = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;
    assign w_revup_ms = i_item.rev_pulled ? i_cfg.revup_full_ms : i_cfg.revup_semi_ms;

    // Next phase.
    always_comb begin
        n_phase  = r_phase;
        w_change = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.fire_pulled && past(w_tick, i_cfg.trigger_hold_ms)) begin
                    n_phase  = PH_REVUP;
                    w_change = 1'b1;
                end
            end
            PH_REVUP: begin
                if (past(w_tick, w_revup_ms)) begin
                    n_phase  = PH_CLEAR;
                    w_change = 1'b1;
                end
            end
            PH_CLEAR: begin
                if (!i_item.plunger_home) begin
                    n_phase  = PH_RUN;
                    w_change = 1'b1;
                end
            end
            PH_RUN: begin
                if (i_item.plunger_home && past(w_tick, i_cfg.end_settle_ms)) begin
                    n_phase  = i_item.rev_pulled ? PH_DELAY : PH_RELEASE;
                    w_change = 1'b1;
                end
            end
            PH_DELAY: begin
                // Releasing rev wins, then re-chambering, then the spin-down timeout.
                if (!i_item.rev_pulled) begin
                    n_phase  = PH_RELEASE;
                    w_change = 1'b1;
                end else if (i_item.fire_pulled && past(w_tick, i_cfg.round_gap_ms)) begin
                    n_phase  = PH_CLEAR;
                    w_change = 1'b1;
                end else if (past(w_tick, i_cfg.revdown_ms)) begin
                    n_phase  = PH_IDLE;
                    w_change = 1'b1;
                end
            end
            PH_RELEASE: begin
                if (!i_item.fire_pulled) begin
                    n_phase  = PH_IDLE;
                    w_change = 1'b1;
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                w_change = 1'b1;
            end
        endcase
    end

    assign n_elapsed = w_change ? '0 : w_tick;

    // Outputs follow the phase held before this item's transition.
    always_comb begin
        o_res.motor_mode     = MODE_BRAKE;
        o_res.motor_duty     = DUTY_FULL;
        o_res.esc_position   = ESC_BRAKE;
        o_res.display_permit = 1'b0;
        o_res.fire_phase     = r_phase;
        unique case (r_phase) inside
            PH_IDLE: begin
                o_res.esc_position   = i_item.rev_pulled ? ESC_PRE_RUN : ESC_BRAKE;
                o_res.display_permit = 1'b1;
            end
            PH_REVUP: begin
                o_res.esc_position = ESC_REVUP;
            end
            PH_CLEAR, PH_RUN: begin
                o_res.motor_mode   = MODE_FWD;
                o_res.motor_duty   = DUTY_BITS'(i_cfg.run_duty);
                o_res.esc_position = ESC_RUN;
            end
            PH_DELAY: begin
                o_res.esc_position = ESC_RUN;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    a_change_clears_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && w_change |=> r_elapsed == '0)
        else $error("phase change did not restart the elapsed count");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_elapsed))
        else $error("phase state moved without an item");

    a_permit_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.display_permit |-> r_phase == PH_IDLE)
        else $error("display permit outside idle");

    a_forward_only_feeding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.motor_mode == MODE_FWD |-> (r_phase == PH_CLEAR || r_phase == PH_RUN))
        else $error("plunger driven forward outside clear or run");

endmodule

[sv/flywheel_plunger_fire_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// Flywheel plunger fire sequencer
// Six-phase firing sequencer: one millisecond tick item in, one drive item out.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+----------------------------
//  in       | input     | i_in_valid/o_in_stall | t_in_item  (trigger, switch)
//  out      | output    | o_out_valid/i_out_stall| t_out_item (motor, esc, phase)
//  cfg      | input     | i_cfg_valid/o_cfg_ready| index 3 bits, data 16 bits
//
// One item per cycle sustained while the output does not stall; an item that is
// taken passes the input register, then the result register, on its way out.
// The phase update and the result for an item are formed in the same cycle
// between those two registers.
// Reset is synchronous: phase goes to idle, the elapsed count to zero, both
// valid flags clear and the registers return to their defaults.
// A stalled result holds its register; the input stalls only when its
// register is full and the result register cannot take the next item.
// ----------------------------------------------------------------------------
module flywheel_plunger_fire_sequencer_unit
    import fpfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_item,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_advance;
    logic      w_accept;
    logic      w_cfg_we;
    t_cfg      w_cfg;
    t_out_item w_res;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_we   = i_cfg_valid && o_cfg_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    fpfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (w_cfg_we),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fpfs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= w_res;
        end
    end

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("item left the input register without reaching the output");

    a_no_overwrite_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_advance)
        else $error("stalled result overwritten");

    a_full_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_advance |=> r_in_valid && $stable(r_in_item))
        else $error("pending input item lost");

endmodule

[tb/sv/fpfs_drive_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fire sequencer drive checker
// Watches the tick, drive and register channels of the fire sequencer. It
// keeps its own copy of the phase, the elapsed count and the registers, works
// out the drive item for every accepted tick and compares each accepted
// drive item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fpfs_drive_checker
    import fpfs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  t_in_item                i_in_item,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  t_out_item               i_out_item,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DAT_BITS-1:0] i_cfg_data,
    output int                      o_mismatch_count,
    output int                      o_pending_count
);

    t_cfg                  settings_q;
    t_phase                phase_q;
    logic [ELAPSED_BITS-1:0] elapsed_q;
    t_out_item             expected_drive_q [$];
    int                    mismatch_count = 0;
    int                    pending_count  = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_pending_count  = pending_count;

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // One millisecond tick: the drive follows the phase held before the tick,
    // then the phase may move on and restart its timer.
    task automatic advance_tick(input t_in_item tick, output t_out_item drv);
        t_phase                  nxt;
        logic                    moved;
        logic [ELAPSED_BITS-1:0] t;
        logic [15:0]             spin_limit;

        if (elapsed_q != '1) begin
            elapsed_q = elapsed_q + 1'b1;
        end
        t = elapsed_q;
        nxt = phase_q;
        moved = 1'b0;
        spin_limit = tick.rev_pulled ? settings_q.revup_full_ms : settings_q.revup_semi_ms;

        drv.motor_mode     = MODE_BRAKE;
        drv.motor_duty     = DUTY_FULL;
        drv.esc_position   = ESC_BRAKE;
        drv.display_permit = 1'b0;
        drv.fire_phase     = phase_q;

        case (phase_q)
            PH_IDLE: begin
                drv.esc_position   = tick.rev_pulled ? ESC_PRE_RUN : ESC_BRAKE;
                drv.display_permit = 1'b1;
                if (tick.fire_pulled && t > settings_q.trigger_hold_ms) begin
                    nxt = PH_REVUP;
                    moved = 1'b1;
                end
            end
            PH_REVUP: begin
                drv.esc_position = ESC_REVUP;
                if (t > spin_limit) begin
                    nxt = PH_CLEAR;
                    moved = 1'b1;
                end
            end
            PH_CLEAR: begin
                drv.motor_mode   = MODE_FWD;
                drv.motor_duty   = settings_q.run_duty;
                drv.esc_position = ESC_RUN;
                if (!tick.plunger_home) begin
                    nxt = PH_RUN;
                    moved = 1'b1;
                end
            end
            PH_RUN: begin
                drv.motor_mode   = MODE_FWD;
                drv.motor_duty   = settings_q.run_duty;
                drv.esc_position = ESC_RUN;
                if (tick.plunger_home && t > settings_q.end_settle_ms) begin
                    nxt = tick.rev_pulled ? PH_DELAY : PH_RELEASE;
                    moved = 1'b1;
                end
            end
            PH_DELAY: begin
                // Releasing rev wins over re-chambering, which wins over spin-down.
                drv.esc_position = ESC_RUN;
                if (!tick.rev_pulled) begin
                    nxt = PH_RELEASE;
                    moved = 1'b1;
                end else if (tick.fire_pulled && t > settings_q.round_gap_ms) begin
                    nxt = PH_CLEAR;
                    moved = 1'b1;
                end else if (t > settings_q.revdown_ms) begin
                    nxt = PH_IDLE;
                    moved = 1'b1;
                end
            end
            PH_RELEASE: begin
                if (!tick.fire_pulled) begin
                    nxt = PH_IDLE;
                    moved = 1'b1;
                end
            end
            default: begin
                nxt = PH_IDLE;
                moved = 1'b1;
            end
        endcase

        if (moved) begin
            phase_q = nxt;
            elapsed_q = '0;
        end
    endtask

    // All block inputs change only at the rising edge, so the falling edge
    // sees what the next rising edge will act on.
    always @(negedge i_clk) begin : watch
        t_out_item drv;
        t_out_item want;

        if (!i_rst_n) begin
            settings_q.run_duty        = RST_RUN_DUTY;
            settings_q.trigger_hold_ms = RST_TRIGGER_HOLD;
            settings_q.round_gap_ms    = RST_ROUND_GAP;
            settings_q.revup_semi_ms   = RST_REVUP_SEMI;
            settings_q.revup_full_ms   = RST_REVUP_FULL;
            settings_q.revdown_ms      = RST_REVDOWN;
            settings_q.end_settle_ms   = RST_END_SETTLE;
            phase_q   = PH_IDLE;
            elapsed_q = '0;
            expected_drive_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RUN_DUTY:     settings_q.run_duty        = i_cfg_data[7:0];
                    CFG_TRIGGER_HOLD: settings_q.trigger_hold_ms = i_cfg_data;
                    CFG_ROUND_GAP:    settings_q.round_gap_ms    = i_cfg_data;
                    CFG_REVUP_SEMI:   settings_q.revup_semi_ms   = i_cfg_data;
                    CFG_REVUP_FULL:   settings_q.revup_full_ms   = i_cfg_data;
                    CFG_REVDOWN:      settings_q.revdown_ms      = i_cfg_data;
                    CFG_END_SETTLE:   settings_q.end_settle_ms   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_tick(i_in_item, drv);
                expected_drive_q.push_back(drv);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_drive_q.size() == 0) begin
                    $error("drive item arrived with no prediction waiting");
                    mismatch_count++;
                end else begin
                    want = expected_drive_q.pop_front();
                    check_field("motor_mode", 32'(want.motor_mode),
                                32'(i_out_item.motor_mode));
                    check_field("motor_duty", 32'(want.motor_duty),
                                32'(i_out_item.motor_duty));
                    check_field("esc_position", 32'(want.esc_position),
                                32'(i_out_item.esc_position));
                    check_field("display_permit", 32'(want.display_permit),
                                32'(i_out_item.display_permit));
                    check_field("fire_phase", 32'(want.fire_phase),
                                32'(i_out_item.fire_phase));
                end
            end
        end
        pending_count = expected_drive_q.size();
    end

endmodule

[tb/sv/tb_flywheel_plunger_fire_sequencer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fire sequencer testbench
// Drives tick items into the fire sequencer through a scripted firing cycle,
// then through random trigger and end-switch sequences under several register
// settings and handshake pressures, then a held trigger against the longest
// hold time, then a random run. A separate checker predicts and compares every drive item.
// ----------------------------------------------------------------------------
module tb_flywheel_plunger_fire_sequencer_unit;
    import fpfs_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int SOAK_TICKS  = 60;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

    // Scripted firing cycle, bits are {fire, rev, home}. It walks every phase,
    // both spin-up delays, each round-delay exit and a release wait hold.
    localparam logic [2:0] OPENING_TICKS [27] = '{
        3'b000, 3'b011, 3'b111, 3'b011, 3'b011, 3'b011, 3'b010, 3'b011, 3'b111,
        3'b110, 3'b101, 3'b101, 3'b000, 3'b100, 3'b100, 3'b110, 3'b111, 3'b011,
        3'b011, 3'b011, 3'b110, 3'b010, 3'b010, 3'b000, 3'b011, 3'b101, 3'b000
    };

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    t_in_item                in_item   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    t_out_item               out_item;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DAT_BITS-1:0] cfg_data  = '0;

    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    int in_burst_left  = 0;
    int out_burst_left = 0;
    int quiet_cycles   = 0;
    int mismatch_count;
    int pending_count;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    flywheel_plunger_fire_sequencer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fpfs_drive_checker u_drive_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_item       (out_item),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    // Drive item receiver with random stalls and occasional stall-free bursts.
    always @(posedge clk) begin
        if (out_burst_left > 0) begin
            out_burst_left <= out_burst_left - 1;
            out_stall <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            out_burst_left <= $urandom_range(20, 80);
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_tick(input t_in_item tick);
        logic stalled;

        if (in_burst_left > 0) begin
            in_burst_left--;
        end else if ($urandom_range(0, 99) == 0) begin
            in_burst_left = $urandom_range(20, 60);
        end else begin
            while ($urandom_range(0, 99) < in_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_item <= tick;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] val);
        logic taken;

        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_count != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] duty, input logic [15:0] hold,
                                 input logic [15:0] gap, input logic [15:0] semi,
                                 input logic [15:0] full, input logic [15:0] down,
                                 input logic [15:0] settle);
        write_reg(CFG_RUN_DUTY, duty);
        write_reg(CFG_TRIGGER_HOLD, hold);
        write_reg(CFG_ROUND_GAP, gap);
        write_reg(CFG_REVUP_SEMI, semi);
        write_reg(CFG_REVUP_FULL, full);
        write_reg(CFG_REVDOWN, down);
        write_reg(CFG_END_SETTLE, settle);
        cfg_valid <= 1'b0;
    endtask

    // Mostly short delays so that random sequences get through every phase.
    function automatic logic [15:0] pick_delay();
        int roll;

        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return 16'hFFFF;
        end else if (roll < 4) begin
            return 16'h0000;
        end
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic logic [15:0] pick_duty();
        int roll;

        roll = $urandom_range(0, 4);
        if (roll == 0) begin
            return 16'hFF00;
        end else if (roll == 1) begin
            return 16'h00FF;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Level modes: held low, held high, noise, or mostly high with dropouts.
    function automatic logic pick_level(input int mode);
        case (mode)
            0:       return 1'b0;
            1:       return 1'b1;
            2:       return 1'($urandom_range(0, 1));
            default: return ($urandom_range(0, 4) != 0);
        endcase
    endfunction

    task automatic run_shots(input int count);
        int       left;
        int       seg_len;
        int       fire_mode;
        int       rev_mode;
        int       home_mode;
        t_in_item tick;

        left = count;
        while (left > 0) begin
            seg_len = $urandom_range(1, 30);
            fire_mode = $urandom_range(0, 3);
            rev_mode = $urandom_range(0, 3);
            home_mode = $urandom_range(0, 3);
            for (int k = 0; k < seg_len && left > 0; k++) begin
                tick.fire_pulled = pick_level(fire_mode);
                tick.rev_pulled = pick_level(rev_mode);
                tick.plunger_home = pick_level(home_mode);
                send_tick(tick);
                left--;
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        t_in_item tick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        in_idle_pct = 35;
        out_stall_pct = 88;
        load_settings(16'hA55A, 16'd0, 16'd0, 16'd0, 16'd1, 16'd2, 16'd0);
        for (int k = 0; k < 27; k++) begin
            send_tick(t_in_item'(OPENING_TICKS[k]));
        end
        wait_drained();
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        cfg_valid <= 1'b0;
        repeat (3) begin
            load_settings(pick_duty(), pick_delay(), pick_delay(), pick_delay(),
                          pick_delay(), pick_delay(), pick_delay());
            run_shots(170);
            wait_drained();
        end

        in_idle_pct = 88;
        out_stall_pct = 35;
        repeat (3) begin
            load_settings(pick_duty(), pick_delay(), pick_delay(), pick_delay(),
                          pick_delay(), pick_delay(), pick_delay());
            run_shots(170);
            wait_drained();
        end

        in_idle_pct = 0;
        out_stall_pct = 0;
        load_settings(16'(RST_RUN_DUTY), RST_TRIGGER_HOLD, RST_ROUND_GAP, RST_REVUP_SEMI,
                      RST_REVUP_FULL, RST_REVDOWN, RST_END_SETTLE);
        run_shots(250);
        wait_drained();

        // With zero delays and fire released, alternating the end switch brings
        // any phase back to idle. A held fire trigger then waits against the
        // longest hold time.
        load_settings(pick_duty(), 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        repeat (4) begin
            send_tick(t_in_item'(3'b000));
            send_tick(t_in_item'(3'b001));
        end
        for (int k = 0; k < SOAK_TICKS; k++) begin
            tick.fire_pulled = 1'b1;
            tick.rev_pulled = 1'($urandom_range(0, 1));
            tick.plunger_home = 1'($urandom_range(0, 1));
            send_tick(tick);
        end
        wait_drained();
        write_reg(CFG_TRIGGER_HOLD, 16'hFFFE);
        cfg_valid <= 1'b0;
        run_shots(40);
        wait_drained();

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
sv/fpfs_pkg.sv
sv/fpfs_cfg.sv
sv/fpfs_core.sv
sv/flywheel_plunger_fire_sequencer_unit.sv
tb/sv/fpfs_drive_checker.sv
tb/sv/tb_flywheel_plunger_fire_sequencer_unit.sv
